/* rtl/core/occ_pkg.sv */
// shared types, codes and digit helpers for the oven cook timer controller
// no dependencies; used by occ_in_stage, occ_fsm and oven_cook_timer_controller
package occ_pkg;

  // held command codes
  localparam logic [3:0] CMD_NONE   = 4'd0;
  localparam logic [3:0] CMD_START  = 4'd1;
  localparam logic [3:0] CMD_TIME   = 4'd2;
  localparam logic [3:0] CMD_CANCEL = 4'd3;
  localparam logic [3:0] CMD_COOK   = 4'd4;
  localparam logic [3:0] CMD_ERROR  = 4'd5;
  localparam logic [3:0] CMD_ALARM  = 4'd6;
  localparam logic [3:0] CMD_FINISH = 4'd7;
  localparam logic [3:0] CMD_HOT    = 4'd8;

  localparam logic [7:0] HOT_THRESHOLD_RESET = 8'd50;
  localparam logic [5:0] SEC_MAX             = 6'd59;

  typedef enum logic [8:0] {
    PH_WELCOME = 9'b000000001,
    PH_TIME    = 9'b000000010,
    PH_TARGET  = 9'b000000100,
    PH_CHECK   = 9'b000001000,
    PH_HEAT    = 9'b000010000,
    PH_WARN    = 9'b000100000,
    PH_CANCEL  = 9'b001000000,
    PH_FINISH  = 9'b010000000,
    PH_ALARM   = 9'b100000000
  } phase_e;

  typedef struct packed {
    logic       start_pressed;
    logic       cancel_pressed;
    logic       door_closed;
    logic       weight_present;
    logic [7:0] temperature;
    logic [6:0] entered_minutes;
    logic [6:0] entered_seconds;
    logic [7:0] entered_target;
    logic       second_tick;
  } item_t;

  // quotient by ten via reciprocal, exact for the whole 8 bit range
  function automatic logic [4:0] div10(input logic [7:0] v);
    logic [15:0] prod;
    prod = 16'(v) * 16'd205;
    return prod[15:11];
  endfunction

  function automatic logic [3:0] mod10(input logic [7:0] v);
    logic [4:0] q;
    logic [7:0] r;
    q = div10(v);
    r = v - 8'(q) * 8'd10;
    return r[3:0];
  endfunction

endpackage

/* rtl/core/oven_cook_timer_controller.sv */
// path: an accepted item goes through the input register, then the phase machine and result register
// throughput: one item per cycle; the input register stalls only while a result is stalled
// reset: welcome phase, no command, digits and time cleared, hot threshold 50
// depends on occ_pkg, occ_in_stage, occ_fsm
module oven_cook_timer_controller (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_valid_i,
  output logic       cfg_ready_o,
  input  logic [7:0] cfg_data_i,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic       start_pressed_i,
  input  logic       cancel_pressed_i,
  input  logic       door_closed_i,
  input  logic       weight_present_i,
  input  logic [7:0] temperature_i,
  input  logic [6:0] entered_minutes_i,
  input  logic [6:0] entered_seconds_i,
  input  logic [7:0] entered_target_i,
  input  logic       second_tick_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [3:0] command_o,
  output logic [3:0] minute_digit_o,
  output logic [3:0] second_tens_o,
  output logic [3:0] second_units_o
);

  occ_pkg::item_t item_in, item_s1;
  logic           s1_valid;
  logic           adv;

  assign cfg_ready_o = 1'b1;

  always_comb begin
    item_in.start_pressed   = start_pressed_i;
    item_in.cancel_pressed  = cancel_pressed_i;
    item_in.door_closed     = door_closed_i;
    item_in.weight_present  = weight_present_i;
    item_in.temperature     = temperature_i;
    item_in.entered_minutes = entered_minutes_i;
    item_in.entered_seconds = entered_seconds_i;
    item_in.entered_target  = entered_target_i;
    item_in.second_tick     = second_tick_i;
  end

  occ_in_stage u_in_stage (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .item_i     (item_in),
    .adv_i      (adv),
    .s1_valid_o (s1_valid),
    .item_o     (item_s1)
  );

  occ_fsm u_fsm (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_data_i     (cfg_data_i),
    .s1_valid_i     (s1_valid),
    .item_i         (item_s1),
    .adv_o          (adv),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .command_o      (command_o),
    .minute_digit_o (minute_digit_o),
    .second_tens_o  (second_tens_o),
    .second_units_o (second_units_o)
  );

endmodule

/* rtl/core/occ_in_stage.sv */
// input register of the oven cook timer controller: holds one polled item
// depends on occ_pkg (item_t)
module occ_in_stage (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  occ_pkg::item_t item_i,
  input  logic          adv_i,
  output logic          s1_valid_o,
  output occ_pkg::item_t item_o
);

  logic           s1_valid_q, s1_valid_d;
  occ_pkg::item_t item_q;
  logic           take;

  // the register frees up whenever the next stage moves
  assign in_stall_o = s1_valid_q && !adv_i;
  assign take       = in_valid_i && !in_stall_o;
  assign s1_valid_d = in_stall_o ? s1_valid_q : in_valid_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= s1_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      item_q <= item_i;
    end
  end

  assign s1_valid_o = s1_valid_q;
  assign item_o     = item_q;

endmodule

/* rtl/core/occ_fsm.sv */
// phase machine, cook time counter and result register of the controller
// depends on occ_pkg (codes, phase_e, item_t, digit helpers)
module occ_fsm (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           cfg_valid_i,
  input  logic [7:0]     cfg_data_i,
  input  logic           s1_valid_i,
  input  occ_pkg::item_t item_i,
  output logic           adv_o,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output logic [3:0]     command_o,
  output logic [3:0]     minute_digit_o,
  output logic [3:0]     second_tens_o,
  output logic [3:0]     second_units_o
);

  occ_pkg::phase_e phase_q, phase_d;
  logic [7:0]  hot_q;
  logic [7:0]  rem_min_q, rem_min_d;   // remaining time kept as minutes : seconds
  logic [5:0]  rem_sec_q, rem_sec_d;
  logic [7:0]  target_q, target_d;
  logic [3:0]  cmd_q, cmd_d;
  logic [11:0] digits_q, digits_d;
  logic        out_valid_q, out_valid_d;
  logic        fire;

  logic [7:0]  norm_min;
  logic [5:0]  norm_sec;
  logic [6:0]  sec_m60, sec_m120;
  logic [4:0]  key_tens;
  logic [4:0]  rem_tens;
  logic        rem_zero;

  assign adv_o       = !(out_valid_q && out_stall_i);
  assign fire        = s1_valid_i && adv_o;
  assign out_valid_d = adv_o ? s1_valid_i : out_valid_q;

  // fold keypad seconds above a minute into the minutes
  assign sec_m60  = item_i.entered_seconds - 7'd60;
  assign sec_m120 = item_i.entered_seconds - 7'd120;
  always_comb begin
    if (item_i.entered_seconds >= 7'd120) begin
      norm_min = {1'b0, item_i.entered_minutes} + 8'd2;
      norm_sec = sec_m120[5:0];
    end else if (item_i.entered_seconds >= 7'd60) begin
      norm_min = {1'b0, item_i.entered_minutes} + 8'd1;
      norm_sec = sec_m60[5:0];
    end else begin
      norm_min = {1'b0, item_i.entered_minutes};
      norm_sec = item_i.entered_seconds[5:0];
    end
  end

  assign key_tens = occ_pkg::div10({1'b0, item_i.entered_seconds});
  assign rem_tens = occ_pkg::div10({2'b0, rem_sec_q});
  assign rem_zero = (rem_min_q == 8'd0) && (rem_sec_q == 6'd0);

  always_comb begin
    phase_d   = phase_q;
    rem_min_d = rem_min_q;
    rem_sec_d = rem_sec_q;
    target_d  = target_q;
    cmd_d     = cmd_q;
    digits_d  = digits_q;
    case (phase_q)
      occ_pkg::PH_TIME: begin
        digits_d  = {occ_pkg::mod10({1'b0, item_i.entered_minutes}),
                     occ_pkg::mod10({3'b0, key_tens}),
                     occ_pkg::mod10({1'b0, item_i.entered_seconds})};
        rem_min_d = norm_min;
        rem_sec_d = norm_sec;
        if ((norm_min != 8'd0) || (norm_sec != 6'd0)) begin
          cmd_d   = occ_pkg::CMD_TIME;
          phase_d = occ_pkg::PH_TARGET;
          if (item_i.cancel_pressed) begin
            cmd_d   = occ_pkg::CMD_CANCEL;
            phase_d = occ_pkg::PH_CANCEL;
          end
        end
      end
      occ_pkg::PH_TARGET: begin
        target_d = item_i.entered_target;
        if (item_i.entered_target != 8'd0) begin
          phase_d = occ_pkg::PH_CHECK;
          if (item_i.cancel_pressed) begin
            cmd_d   = occ_pkg::CMD_CANCEL;
            phase_d = occ_pkg::PH_CANCEL;
          end
        end
      end
      occ_pkg::PH_CHECK: begin
        if (item_i.door_closed && item_i.weight_present) begin
          cmd_d   = occ_pkg::CMD_COOK;
          phase_d = occ_pkg::PH_HEAT;
        end else begin
          cmd_d = occ_pkg::CMD_ERROR;
          if (item_i.cancel_pressed) begin
            cmd_d   = occ_pkg::CMD_CANCEL;
            phase_d = occ_pkg::PH_CANCEL;
          end
        end
      end
      occ_pkg::PH_HEAT: begin
        if (item_i.second_tick) begin
          if (rem_zero) begin
            cmd_d   = occ_pkg::CMD_FINISH;
            phase_d = occ_pkg::PH_FINISH;
          end else if (item_i.temperature > target_q) begin
            cmd_d   = occ_pkg::CMD_ALARM;
            phase_d = occ_pkg::PH_ALARM;
          end else if (item_i.cancel_pressed) begin
            cmd_d   = occ_pkg::CMD_CANCEL;
            phase_d = occ_pkg::PH_CANCEL;
          end else begin
            digits_d = {occ_pkg::mod10(rem_min_q),
                        rem_tens[3:0],
                        occ_pkg::mod10({2'b0, rem_sec_q})};
            if (rem_sec_q == 6'd0) begin
              rem_sec_d = occ_pkg::SEC_MAX;
              rem_min_d = rem_min_q - 8'd1;
            end else begin
              rem_sec_d = rem_sec_q - 6'd1;
            end
            // last second just counted off
            if ((rem_min_q == 8'd0) && (rem_sec_q == 6'd1)) begin
              cmd_d   = occ_pkg::CMD_FINISH;
              phase_d = occ_pkg::PH_FINISH;
            end
          end
        end
      end
      occ_pkg::PH_WARN, occ_pkg::PH_FINISH, occ_pkg::PH_ALARM: begin
        if (phase_q != occ_pkg::PH_WARN) begin
          rem_min_d = 8'd0;
          rem_sec_d = 6'd0;
          target_d  = 8'd0;
          digits_d  = 12'd0;
        end
        if (item_i.temperature >= hot_q) begin
          cmd_d   = occ_pkg::CMD_HOT;
          phase_d = occ_pkg::PH_WARN;
        end else begin
          cmd_d   = occ_pkg::CMD_NONE;
          phase_d = occ_pkg::PH_WELCOME;
        end
      end
      occ_pkg::PH_CANCEL: begin
        rem_min_d = 8'd0;
        rem_sec_d = 6'd0;
        target_d  = 8'd0;
        digits_d  = 12'd0;
        phase_d   = occ_pkg::PH_WELCOME;
      end
      default: begin
        if (item_i.start_pressed) begin
          cmd_d   = occ_pkg::CMD_START;
          phase_d = occ_pkg::PH_TIME;
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= occ_pkg::PH_WELCOME;
      hot_q       <= occ_pkg::HOT_THRESHOLD_RESET;
      rem_min_q   <= 8'd0;
      rem_sec_q   <= 6'd0;
      target_q    <= 8'd0;
      cmd_q       <= occ_pkg::CMD_NONE;
      digits_q    <= 12'd0;
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      if (cfg_valid_i) begin
        hot_q <= cfg_data_i;
      end
      if (fire) begin
        phase_q   <= phase_d;
        rem_min_q <= rem_min_d;
        rem_sec_q <= rem_sec_d;
        target_q  <= target_d;
        cmd_q     <= cmd_d;
        digits_q  <= digits_d;
      end
    end
  end

  // the held command and digits double as the result register
  assign out_valid_o    = out_valid_q;
  assign command_o      = cmd_q;
  assign minute_digit_o = digits_q[11:8];
  assign second_tens_o  = digits_q[7:4];
  assign second_units_o = digits_q[3:0];

  a_sec_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rem_sec_q <= occ_pkg::SEC_MAX)
    else $error("remaining seconds out of range");

  a_heat_cmd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == occ_pkg::PH_HEAT) |-> (cmd_q == occ_pkg::CMD_COOK))
    else $error("heating without cook command");

  a_warn_cmd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == occ_pkg::PH_WARN) |-> (cmd_q == occ_pkg::CMD_HOT))
    else $error("warning without hot command");

  a_cancel_cmd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == occ_pkg::PH_CANCEL) |-> (cmd_q == occ_pkg::CMD_CANCEL))
    else $error("cancel phase without cancel command");

  a_hold_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_stall_i) |=> $stable(cmd_q) && $stable(digits_q))
    else $error("result changed while stalled");

endmodule

/* verif/occ_tb_pkg.sv */
// cook readout predictor and checker for the oven cook timer controller testbench
// depends on occ_pkg for the item type, the command codes and the phase enum
package occ_tb_pkg;
  import occ_pkg::*;

  typedef struct packed {
    logic [3:0] command;
    logic [3:0] minute_digit;
    logic [3:0] second_tens;
    logic [3:0] second_units;
  } readout_t;

  class cook_readout_board;
    logic [7:0]  threshold = HOT_THRESHOLD_RESET;
    phase_e      ph = PH_WELCOME;
    logic [12:0] remaining_s = '0;
    logic [7:0]  target_t = '0;
    logic [3:0]  held_cmd = CMD_NONE;
    logic [11:0] digits = '0;
    readout_t    readouts_due[$];
    int          errors, polls, cooks_done, alarms, cancels, hot_holds;

    function void set_threshold(logic [7:0] v);
      threshold = v;
    endfunction

    function int pending();
      return readouts_due.size();
    endfunction

    function void set_digits(int unsigned m, int unsigned s);
      digits = {4'(m % 10), 4'((s / 10) % 10), 4'(s % 10)};
    endfunction

    function void to_cancel();
      held_cmd = CMD_CANCEL;
      ph = PH_CANCEL;
      cancels++;
    endfunction

    // after a cook ends the oven may still be too hot to touch
    function void settle_hot(logic [7:0] temp);
      if (temp >= threshold) begin
        held_cmd = CMD_HOT;
        ph = PH_WARN;
        hot_holds++;
      end else begin
        held_cmd = CMD_NONE;
        ph = PH_WELCOME;
      end
    endfunction

    function void clear_cook();
      remaining_s = '0;
      target_t = '0;
      digits = '0;
    endfunction

    function void note_poll(item_t p);
      polls++;
      case (ph)
        PH_TIME: begin
          set_digits(p.entered_minutes, p.entered_seconds);
          remaining_s = 13'(int'(p.entered_minutes) * 60 + int'(p.entered_seconds));
          if (remaining_s != 0) begin
            held_cmd = CMD_TIME;
            ph = PH_TARGET;
            if (p.cancel_pressed) to_cancel();
          end
        end
        PH_TARGET: begin
          target_t = p.entered_target;
          if (target_t != 0) begin
            ph = PH_CHECK;
            if (p.cancel_pressed) to_cancel();
          end
        end
        PH_CHECK: begin
          if (p.door_closed && p.weight_present) begin
            held_cmd = CMD_COOK;
            ph = PH_HEAT;
          end else begin
            held_cmd = CMD_ERROR;
            if (p.cancel_pressed) to_cancel();
          end
        end
        PH_HEAT: begin
          if (p.second_tick) begin
            if (remaining_s == 0) begin
              held_cmd = CMD_FINISH;
              ph = PH_FINISH;
              cooks_done++;
            end else if (p.temperature > target_t) begin
              held_cmd = CMD_ALARM;
              ph = PH_ALARM;
              alarms++;
            end else if (p.cancel_pressed) begin
              to_cancel();
            end else begin
              set_digits(remaining_s / 60, remaining_s % 60);
              remaining_s = remaining_s - 13'd1;
              if (remaining_s == 0) begin
                held_cmd = CMD_FINISH;
                ph = PH_FINISH;
                cooks_done++;
              end
            end
          end
        end
        PH_WARN: settle_hot(p.temperature);
        PH_CANCEL: begin
          clear_cook();
          ph = PH_WELCOME;
        end
        PH_FINISH, PH_ALARM: begin
          clear_cook();
          settle_hot(p.temperature);
        end
        default: begin
          if (p.start_pressed) begin
            held_cmd = CMD_START;
            ph = PH_TIME;
          end
        end
      endcase
      readouts_due.push_back({held_cmd, digits});
    endfunction

    function void cmp_field(string name, logic [3:0] want, logic [3:0] got);
      if (want !== got) begin
        $display("%0t mismatch %s: expected %0d, actual %0d", $time, name, want, got);
        errors++;
      end
    endfunction

    function void check_readout(readout_t got);
      readout_t want;
      if (readouts_due.size() == 0) begin
        $display("%0t unexpected readout: expected none, actual cmd %0d digits %0d%0d%0d",
                 $time, got.command, got.minute_digit, got.second_tens, got.second_units);
        errors++;
        return;
      end
      want = readouts_due.pop_front();
      cmp_field("command", want.command, got.command);
      cmp_field("minute_digit", want.minute_digit, got.minute_digit);
      cmp_field("second_tens", want.second_tens, got.second_tens);
      cmp_field("second_units", want.second_units, got.second_units);
    endfunction
  endclass

endpackage

/* verif/tb.sv */
// testbench for oven_cook_timer_controller: directed cook sequences, then phase-aware
// random polls under several hot thresholds and idle/stall mixes; depends on occ_pkg, occ_tb_pkg
module tb;
  import occ_pkg::*;
  import occ_tb_pkg::*;

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       cfg_valid = 1'b0;
  logic [7:0] cfg_data = '0;
  logic       in_valid = 1'b0;
  item_t      poll_q = '0;
  logic       out_stall = 1'b0;
  logic       cfg_ready_o, in_stall_o, out_valid_o;
  logic [3:0] command_o, minute_digit_o, second_tens_o, second_units_o;
  int         send_idle_pct = 0;
  int         recv_stall_pct = 0;

  cook_readout_board sb = new;

  oven_cook_timer_controller dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_valid_i      (cfg_valid),
    .cfg_ready_o      (cfg_ready_o),
    .cfg_data_i       (cfg_data),
    .in_valid_i       (in_valid),
    .in_stall_o       (in_stall_o),
    .start_pressed_i  (poll_q.start_pressed),
    .cancel_pressed_i (poll_q.cancel_pressed),
    .door_closed_i    (poll_q.door_closed),
    .weight_present_i (poll_q.weight_present),
    .temperature_i    (poll_q.temperature),
    .entered_minutes_i(poll_q.entered_minutes),
    .entered_seconds_i(poll_q.entered_seconds),
    .entered_target_i (poll_q.entered_target),
    .second_tick_i    (poll_q.second_tick),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall),
    .command_o        (command_o),
    .minute_digit_o   (minute_digit_o),
    .second_tens_o    (second_tens_o),
    .second_units_o   (second_units_o)
  );

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  initial begin
    #2_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

  // readout side: values read here are the ones from before the edge
  initial begin
    forever begin
      @(posedge clk_i);
      if (rst_ni && out_valid_o && !out_stall)
        sb.check_readout({command_o, minute_digit_o, second_tens_o, second_units_o});
      out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
    end
  end

  function automatic item_t poll(bit st, bit cn, bit dr, bit wt, int temp, int mins,
                                 int secs, int tgt, bit tick);
    item_t p;
    p.start_pressed   = st;
    p.cancel_pressed  = cn;
    p.door_closed     = dr;
    p.weight_present  = wt;
    p.temperature     = 8'(temp);
    p.entered_minutes = 7'(mins);
    p.entered_seconds = 7'(secs);
    p.entered_target  = 8'(tgt);
    p.second_tick     = tick;
    return p;
  endfunction

  // mostly well-formed cook sequences steered by the predicted phase, some noise
  function automatic item_t make_poll();
    item_t p;
    int r, lo, hi;
    p = poll($urandom_range(0, 1), $urandom_range(0, 1), $urandom_range(0, 1),
             $urandom_range(0, 1), $urandom_range(0, 255), $urandom_range(0, 127),
             $urandom_range(0, 127), $urandom_range(0, 255), $urandom_range(0, 1));
    if ($urandom_range(0, 99) < 10) return p;
    p.cancel_pressed = ($urandom_range(0, 99) < 4);
    case (sb.ph)
      PH_WELCOME: p.start_pressed = ($urandom_range(0, 99) < 80);
      PH_TIME: begin
        r = $urandom_range(0, 99);
        if (r < 8) begin
          p.entered_minutes = '0;
          p.entered_seconds = '0;
        end else if (r < 12) begin
          p.entered_minutes = 7'($urandom_range(60, 127));
        end else begin
          p.entered_minutes = 7'($urandom_range(0, 1));
          p.entered_seconds = 7'($urandom_range(0, 25));
        end
      end
      PH_TARGET: p.entered_target = ($urandom_range(0, 99) < 8) ? 8'd0
                                                                 : 8'($urandom_range(1, 255));
      PH_CHECK: begin
        if ($urandom_range(0, 99) < 80) begin
          p.door_closed = 1'b1;
          p.weight_present = 1'b1;
        end
      end
      PH_HEAT: begin
        p.second_tick = ($urandom_range(0, 99) < 70);
        if ($urandom_range(0, 99) < 96) p.temperature = 8'($urandom_range(0, sb.target_t));
      end
      default: begin
        // ends of a cook: keep the temperature near the hot threshold
        lo = (sb.threshold > 3) ? sb.threshold - 3 : 0;
        hi = (sb.threshold < 252) ? sb.threshold + 3 : 255;
        if ($urandom_range(0, 1)) p.temperature = 8'($urandom_range(lo, hi));
      end
    endcase
    return p;
  endfunction

  task automatic send_poll(item_t p);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk_i);
    end
    in_valid <= 1'b1;
    poll_q <= p;
    do @(posedge clk_i); while (in_stall_o);
    sb.note_poll(p);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_threshold(logic [7:0] v);
    cfg_valid <= 1'b1;
    cfg_data <= v;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid <= 1'b0;
    sb.set_threshold(v);
  endtask

  initial begin
    logic [7:0] thr_list[8];
    item_t dir_polls[$];
    thr_list = '{8'd255, 8'd0, 8'd50, 8'd1, 8'd254, 8'd128,
                 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255))};
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    write_threshold(8'd100);

    // zero time, oversize entries with cancel, door and load errors, finish, hot hold, alarm
    dir_polls = '{poll(0, 0, 0, 0, 0, 0, 0, 0, 0), poll(1, 0, 0, 0, 0, 0, 0, 0, 0),
                  poll(0, 0, 0, 0, 0, 0, 0, 0, 0), poll(0, 1, 0, 0, 0, 127, 127, 0, 0),
                  poll(0, 0, 0, 0, 0, 0, 0, 0, 0), poll(1, 0, 0, 0, 0, 0, 0, 0, 0),
                  poll(0, 0, 0, 0, 0, 0, 2, 0, 0), poll(0, 0, 0, 0, 0, 0, 0, 0, 0),
                  poll(0, 0, 0, 0, 0, 0, 0, 255, 0), poll(0, 0, 0, 1, 0, 0, 0, 0, 0),
                  poll(0, 0, 1, 0, 0, 0, 0, 0, 0), poll(0, 0, 1, 1, 0, 0, 0, 0, 0),
                  poll(0, 0, 1, 1, 255, 0, 0, 0, 0), poll(0, 0, 1, 1, 255, 0, 0, 0, 1),
                  poll(0, 0, 1, 1, 0, 0, 0, 0, 1), poll(0, 0, 0, 0, 100, 0, 0, 0, 0),
                  poll(0, 0, 0, 0, 99, 0, 0, 0, 0), poll(1, 0, 0, 0, 0, 0, 0, 0, 0),
                  poll(0, 0, 0, 0, 0, 1, 0, 0, 0), poll(0, 0, 0, 0, 0, 0, 0, 10, 0),
                  poll(0, 0, 1, 1, 0, 0, 0, 0, 0), poll(0, 0, 1, 1, 11, 0, 0, 0, 1),
                  poll(0, 0, 0, 0, 0, 0, 0, 0, 0)};
    foreach (dir_polls[i]) send_poll(dir_polls[i]);

    for (int seg = 0; seg < 8; seg++) begin
      drain();
      write_threshold(thr_list[seg]);
      case (seg % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 82; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 82; end
        default: begin send_idle_pct = 20; recv_stall_pct = 20; end
      endcase
      repeat (200) send_poll(make_poll());
    end

    drain();
    repeat (6) @(posedge clk_i);
    if (sb.pending() != 0) begin
      $display("%0t missing readouts: expected %0d more, actual none", $time, sb.pending());
      sb.errors++;
    end
    $display("covered %0d polls under 9 hot thresholds and four idle/stall mixes",
             sb.polls);
    $display("cooks finished %0d, overheat alarms %0d, cancels %0d, still-hot holds %0d",
             sb.cooks_done, sb.alarms, sb.cancels, sb.hot_holds);
    if (sb.errors == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

endmodule
